// File: design/dfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the length-prefixed field deframer
// Status codes, the result record and the defaults used by the deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int DFR_MAX_PREFIX_DEF = 5;
	localparam logic [31:0] DFR_MAX_FIELD_RESET = 32'hFFFF_FFFF;

	// Bit 7 of a prefix byte marks that another prefix byte follows.
	localparam int DFR_CONT_BIT = 7;
	localparam int DFR_DIGIT_BITS = 7;

	typedef enum logic [1:0] {
		ST_DATA       = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_BAD_PREFIX = 2'd2,
		ST_TOO_LARGE  = 2'd3
	} dfr_status_t;

	typedef struct packed {
		dfr_status_t status;
		logic [7:0]  data_byte;
		logic        last;
		logic [31:0] field_length;
	} dfr_result_t;

endpackage : dfr_pkg
`default_nettype wire

// File: design/dfr_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_in_stage: input register of the deframer
// Holds one incoming byte until the parser consumes it.
// ----------------------------------------------------------------------------
module dfr_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	input  wire logic       advance,
	output logic            in_stall,
	output logic            valid_s1,
	output logic [7:0]      data_s1
);

	logic load_en;

	// The register can take a new request when it is empty or drains this cycle.
	assign load_en  = !valid_s1 || advance;
	assign in_stall = !load_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && in_valid) begin
			data_s1 <= in_byte;
		end
	end

endmodule : dfr_in_stage
`default_nettype wire

// File: design/dfr_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_parse: prefix decoder and payload counter
// Folds base-128 prefix digits into a length, checks the size limit and
// counts payload bytes. Produces at most one result per consumed byte.
// ----------------------------------------------------------------------------
module dfr_parse
	import dfr_pkg::*;
#(
	parameter int MAX_PREFIX_BYTES = DFR_MAX_PREFIX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [31:0] cfg_data,
	input  wire logic [7:0]  data_s1,
	input  wire logic        advance,
	output logic             produce,
	output dfr_result_t      result
);

	localparam int CntW = $clog2(MAX_PREFIX_BYTES + 1);

	logic [31:0]     max_field_q;
	logic            in_payload_q;
	logic [31:0]     length_accum_q;
	logic [CntW-1:0] prefix_cnt_q;
	logic [31:0]     bytes_left_q;

	logic            in_payload_d;
	logic [31:0]     length_accum_d;
	logic [CntW-1:0] prefix_cnt_d;
	logic [31:0]     bytes_left_d;

	logic [31:0]     acc_next;
	logic [CntW-1:0] cnt_next;
	logic [31:0]     left_next;
	logic [32:0]     total;

	assign acc_next  = {length_accum_q[31-DFR_DIGIT_BITS:0], data_s1[DFR_DIGIT_BITS-1:0]};
	assign cnt_next  = prefix_cnt_q + CntW'(1);
	assign left_next = bytes_left_q - 32'd1;
	// Field size is taken at 33 bits so that the sum never wraps.
	assign total     = {1'b0, acc_next} + 33'(cnt_next);

	always_comb begin
		in_payload_d   = in_payload_q;
		length_accum_d = length_accum_q;
		prefix_cnt_d   = prefix_cnt_q;
		bytes_left_d   = bytes_left_q;
		produce        = 1'b0;
		result.status       = ST_DATA;
		result.data_byte    = 8'd0;
		result.last         = 1'b0;
		result.field_length = 32'd0;

		if (in_payload_q) begin
			produce             = 1'b1;
			result.data_byte    = data_s1;
			result.field_length = length_accum_q;
			bytes_left_d        = left_next;
			if (left_next == 32'd0) begin
				result.last    = 1'b1;
				in_payload_d   = 1'b0;
				length_accum_d = 32'd0;
				prefix_cnt_d   = '0;
			end
		end else if (data_s1[DFR_CONT_BIT]) begin
			if (cnt_next >= CntW'(MAX_PREFIX_BYTES)) begin
				produce        = 1'b1;
				result.status  = ST_BAD_PREFIX;
				result.last    = 1'b1;
				length_accum_d = 32'd0;
				prefix_cnt_d   = '0;
			end else begin
				length_accum_d = acc_next;
				prefix_cnt_d   = cnt_next;
			end
		end else if (total > {1'b0, max_field_q}) begin
			produce             = 1'b1;
			result.status       = ST_TOO_LARGE;
			result.last         = 1'b1;
			result.field_length = acc_next;
			length_accum_d      = 32'd0;
			prefix_cnt_d        = '0;
		end else if (acc_next == 32'd0) begin
			produce        = 1'b1;
			result.status  = ST_EMPTY;
			result.last    = 1'b1;
			length_accum_d = 32'd0;
			prefix_cnt_d   = '0;
		end else begin
			in_payload_d   = 1'b1;
			length_accum_d = acc_next;
			prefix_cnt_d   = '0;
			bytes_left_d   = acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_field_q <= DFR_MAX_FIELD_RESET;
		end else if (cfg_valid) begin
			max_field_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q   <= 1'b0;
			length_accum_q <= 32'd0;
			prefix_cnt_q   <= '0;
			bytes_left_q   <= 32'd0;
		end else if (advance) begin
			in_payload_q   <= in_payload_d;
			length_accum_q <= length_accum_d;
			prefix_cnt_q   <= prefix_cnt_d;
			bytes_left_q   <= bytes_left_d;
		end
	end

	a_payload_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> bytes_left_q != 32'd0)
		else $error("payload state with no bytes left");

	a_prefix_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_payload_q |-> bytes_left_q == 32'd0)
		else $error("byte count left over outside a payload");

	a_prefix_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_cnt_q < CntW'(MAX_PREFIX_BYTES))
		else $error("prefix count reached its limit without an error");

	a_payload_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> prefix_cnt_q == '0)
		else $error("prefix count not cleared during payload");

endmodule : dfr_parse
`default_nettype wire

// File: design/dfr_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_out_reg: result register of the deframer
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dfr_out_reg
	import dfr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire dfr_result_t result,
	input  wire logic  out_stall,
	output logic       out_free,
	output logic       out_valid,
	output dfr_result_t result_q
);

	// The register is free when empty or when its request is taken this cycle.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule : dfr_out_reg
`default_nettype wire

// File: design/length_prefixed_field_deframer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_field_deframer_unit: base-128 length-prefixed deframer
// Splits a byte stream into fields, passes payload bytes on and reports
// empty fields, bad prefixes and oversized fields.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_stall | in_byte
//  out     | output    | out_valid/out_stall | status, data_byte, last,
//          |           |                     | field_length
//  cfg     | input     | cfg_valid/cfg_ready | max_field_bytes
//
// One byte is accepted per clock while no waiting result holds it back. The
// rate is set by the combinational parse step between the input register
// and the result register. A waiting result holds back only a byte that
// makes a result of its own; prefix bytes that make none are still parsed.
// Reset clears the parser state and sets the size limit to its largest
// value. cfg_ready is always high.
// ----------------------------------------------------------------------------
module length_prefixed_field_deframer_unit
	import dfr_pkg::*;
#(
	parameter int MAX_PREFIX_BYTES = DFR_MAX_PREFIX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       data_byte,
	output logic             last,
	output logic [31:0]      field_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] max_field_bytes
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        advance;
	logic        produce;
	logic        out_free;
	dfr_result_t result;
	dfr_result_t result_q;

	// A byte moves on unless it makes a result and the result register is full.
	assign advance   = valid_s1 && (out_free || !produce);
	assign cfg_ready = 1'b1;

	dfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.advance  (advance),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	dfr_parse #(
		.MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (max_field_bytes),
		.data_s1   (data_s1),
		.advance   (advance),
		.produce   (produce),
		.result    (result)
	);

	dfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && produce),
		.result    (result),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign status       = result_q.status;
	assign data_byte    = result_q.data_byte;
	assign last         = result_q.last;
	assign field_length = result_q.field_length;

endmodule : length_prefixed_field_deframer_unit
`default_nettype wire

// File: sim/length_prefixed_field_deframer_checker.sv
// ----------------------------------------------------------------------------
// length_prefixed_field_deframer_checker: result checker for the deframer
// Watches the byte, result and register channels, decodes the byte stream on
// its own and compares every result request with the one it predicts.
// ----------------------------------------------------------------------------
module length_prefixed_field_deframer_checker
	import dfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic [31:0] field_length,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] max_field_bytes,
	output int          fail_count,
	output int          results_due
);

	localparam int REPORT_CAP = 40;

	logic        reading_payload;
	logic [31:0] decoded_length;
	int          prefix_bytes;
	logic [31:0] payload_left;
	logic [31:0] size_limit;
	dfr_result_t due_results[$];
	dfr_result_t seen;
	dfr_result_t oldest;
	dfr_result_t made;

	initial begin
		fail_count = 0;
		results_due = 0;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < REPORT_CAP) begin
			$display("%0t: mismatch: %s", $time, msg);
		end
		fail_count++;
	endtask

	function automatic void start_field();
		reading_payload = 1'b0;
		decoded_length = '0;
		prefix_bytes = 0;
		payload_left = '0;
	endfunction

	// Returns 1 when the byte produces a result, which is then left in res.
	function automatic bit deframe_byte(input logic [7:0] b, output dfr_result_t res);
		logic [32:0] field_total;
		res = '0;
		res.last = 1'b1;
		if (reading_payload) begin
			payload_left = payload_left - 32'd1;
			res.status = ST_DATA;
			res.data_byte = b;
			res.last = (payload_left == 32'd0);
			res.field_length = decoded_length;
			if (payload_left == 32'd0) start_field();
			return 1'b1;
		end
		decoded_length = {decoded_length[31-DFR_DIGIT_BITS:0], b[DFR_DIGIT_BITS-1:0]};
		prefix_bytes++;
		if (b[DFR_CONT_BIT]) begin
			if (prefix_bytes < DFR_MAX_PREFIX_DEF) return 1'b0;
			res.status = ST_BAD_PREFIX;
			start_field();
			return 1'b1;
		end
		// The size check is done one bit wider so that it cannot wrap.
		field_total = {1'b0, decoded_length} + 33'(prefix_bytes);
		if (field_total > {1'b0, size_limit}) begin
			res.status = ST_TOO_LARGE;
			res.field_length = decoded_length;
			start_field();
			return 1'b1;
		end
		if (decoded_length == 32'd0) begin
			res.status = ST_EMPTY;
			start_field();
			return 1'b1;
		end
		reading_payload = 1'b1;
		payload_left = decoded_length;
		prefix_bytes = 0;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_field();
			size_limit = DFR_MAX_FIELD_RESET;
			due_results.delete();
			results_due = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {status, data_byte, last, field_length};
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d byte %02h",
						status, data_byte));
				end else begin
					oldest = due_results.pop_front();
					if (seen.status != oldest.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							seen.status, oldest.status));
					if (seen.data_byte != oldest.data_byte)
						report_mismatch($sformatf("data_byte %02h, expected %02h",
							seen.data_byte, oldest.data_byte));
					if (seen.last != oldest.last)
						report_mismatch($sformatf("last %0b, expected %0b",
							seen.last, oldest.last));
					if (seen.field_length != oldest.field_length)
						report_mismatch($sformatf("field_length %08h, expected %08h",
							seen.field_length, oldest.field_length));
				end
			end
			if (in_valid && !in_stall) begin
				if (deframe_byte(in_byte, made)) due_results.push_back(made);
			end
			if (cfg_valid && cfg_ready) size_limit = max_field_bytes;
			results_due = due_results.size();
		end
	end

endmodule : length_prefixed_field_deframer_checker

// File: sim/tb_length_prefixed_field_deframer_unit.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_field_deframer_unit: testbench of the field deframer
// Sends directed and random byte streams of length-prefixed fields under
// several size limits, with random gaps and output stalls, and leaves the
// checking to the checker module that sits beside the block.
// ----------------------------------------------------------------------------
module tb_length_prefixed_field_deframer_unit;
	import dfr_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int ITEM_TARGET  = 1550;
	localparam int PHASE_BYTES  = 140;
	localparam int MAX_IDLE     = 6;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_FIELD   = 300;
	localparam int CYCLE_LIMIT  = 250000;

	// Empty field, one-byte field, padded prefixes, a bad prefix, an all-ones
	// length that only fails without wrap, and dropped high length bits.
	localparam logic [7:0] DIRECTED_BYTES [27] = '{
		8'h00,
		8'h01, 8'hFF,
		8'h80, 8'h02, 8'h00, 8'hA5,
		8'h80, 8'h00,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'h03, 8'h11, 8'h22, 8'h33
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  data_byte;
	logic        last;
	logic [31:0] field_length;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] max_field_bytes;

	int          fail_count;
	int          results_due;
	int          bytes_sent;
	int          cycle_count;
	logic [31:0] field_limit;
	bit          idle_on;

	length_prefixed_field_deframer_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.data_byte      (data_byte),
		.last           (last),
		.field_length   (field_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_field_bytes(max_field_bytes)
	);

	length_prefixed_field_deframer_checker deframe_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.data_byte      (data_byte),
		.last           (last),
		.field_length   (field_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_field_bytes(max_field_bytes),
		.fail_count     (fail_count),
		.results_due    (results_due)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL length_prefixed_field_deframer_unit");
			$finish;
		end
	end

	// After each accepted result the receiver may raise out_stall for a random hold.
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
				@(negedge clk);
				if (hold > 0) begin
					out_stall = 1'b1;
					repeat (hold) @(negedge clk);
					out_stall = 1'b0;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] value);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_byte = value;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		while (results_due != 0) @(negedge clk);
		// Prefix bytes give no result, so let the pipeline settle as well.
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		drain_results();
		cfg_valid = 1'b1;
		max_field_bytes = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		field_limit = value;
	endtask

	// True when the block will go on to take the payload of this field.
	function automatic bit fits(input logic [31:0] len, input int n);
		return ({1'b0, len} + 33'(n)) <= {1'b0, field_limit};
	endfunction

	function automatic int prefix_size(input logic [31:0] len, input int pad);
		int digits;
		digits = 1;
		while (digits < DFR_MAX_PREFIX_DEF && ({32'b0, len} >> (DFR_DIGIT_BITS * digits)) != 0)
			digits++;
		return (digits + pad > DFR_MAX_PREFIX_DEF) ? DFR_MAX_PREFIX_DEF : digits + pad;
	endfunction

	task automatic send_length(input logic [31:0] len, input int n);
		logic [63:0] wide;
		logic [7:0]  b;
		wide = {32'b0, len};
		for (int i = n - 1; i >= 0; i--) begin
			b = {1'b0, 7'(wide >> (DFR_DIGIT_BITS * i))};
			if (i > 0) b[DFR_CONT_BIT] = 1'b1;
			// In a five-byte prefix these bits land above bit 31 and are dropped.
			if (i == 4) b[6:4] = 3'($urandom);
			send_byte(b);
		end
	endtask

	task automatic send_noise();
		logic [7:0]  raw [5];
		logic [31:0] len;
		int          n;
		n = $urandom_range(1, DFR_MAX_PREFIX_DEF);
		len = '0;
		for (int i = 0; i < 5; i++) raw[i] = 8'($urandom);
		for (int i = 0; i < n; i++) begin
			if (i < n - 1) raw[i][DFR_CONT_BIT] = 1'b1;
			else if (n < DFR_MAX_PREFIX_DEF) raw[i][DFR_CONT_BIT] = 1'b0;
			len = {len[31-DFR_DIGIT_BITS:0], raw[i][DFR_DIGIT_BITS-1:0]};
		end
		// A long accepted payload would stall the run, so it becomes a bad prefix.
		if (!raw[n-1][DFR_CONT_BIT] && fits(len, n) && len > LONG_FIELD) begin
			for (int i = n - 1; i < 5; i++) raw[i][DFR_CONT_BIT] = 1'b1;
			n = DFR_MAX_PREFIX_DEF;
		end
		for (int i = 0; i < n; i++) send_byte(raw[i]);
		if (!raw[n-1][DFR_CONT_BIT] && fits(len, n)) repeat (len) send_byte(8'($urandom));
	endtask

	task automatic send_field();
		int          kind;
		int          pad;
		int          n;
		logic [31:0] len;
		kind = $urandom_range(0, 99);
		pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (kind < 70) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(41, LONG_FIELD);
				1, 2, 3: len = $urandom_range(9, 40);
				default: len = $urandom_range(0, 8);
			endcase
			n = prefix_size(len, pad);
			send_length(len, n);
			if (fits(len, n)) repeat (len) send_byte(8'($urandom));
		end else if (kind < 80) begin
			repeat (DFR_MAX_PREFIX_DEF) send_byte(8'($urandom) | 8'h80);
		end else if (kind < 90) begin
			len = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF;
			if (field_limit < 32'h8000_0000 && $urandom_range(0, 1))
				len = field_limit + $urandom_range(0, 3);
			n = prefix_size(len, pad);
			// An all-ones length is too large under every limit.
			if (fits(len, n)) begin
				len = 32'hFFFF_FFFF;
				n = DFR_MAX_PREFIX_DEF;
			end
			send_length(len, n);
		end else begin
			send_noise();
		end
	endtask

	initial begin
		int phase_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		cfg_valid = 1'b0;
		max_field_bytes = '0;
		field_limit = DFR_MAX_FIELD_RESET;
		idle_on = 1'b1;
		bytes_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

		for (int phase = 0; bytes_sent < ITEM_TARGET; phase++) begin
			case (phase % 8)
				0: write_limit(32'hFFFF_FFFF);
				1: write_limit(32'd1);
				2: write_limit(32'd0);
				3: write_limit($urandom_range(2, 60));
				4: write_limit(32'hFFFF_FFFE);
				5: write_limit(32'd12);
				6: write_limit($urandom);
				default: write_limit(32'd5);
			endcase
			idle_on = (phase % 3 != 2);
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(0, 49) == 0) drain_results();
				send_field();
			end
		end

		drain_results();
		if (fail_count == 0) begin
			$display("PASS length_prefixed_field_deframer_unit");
		end else begin
			$display("FAIL length_prefixed_field_deframer_unit");
		end
		$finish;
	end

endmodule : tb_length_prefixed_field_deframer_unit
